// ===== rtl/ivt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivt_pkg
// Shared types and constants for the indexed vector table and its cells.
// ----------------------------------------------------------------------------
package ivt_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CMP_W-1:0]     cmp_t;

    typedef enum logic [KIND_W-1:0] {
        REQ_GET    = 3'd0,
        REQ_SET    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_ERASE  = 3'd3,
        REQ_PUSH   = 3'd4,
        REQ_POP    = 3'd5,
        REQ_REMOVE = 3'd6,
        REQ_CLEAR  = 3'd7
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_MISSING = 3'd4
    } status_t;

    typedef struct packed {
        logic  capture;
        logic  apply;
        req_t  kind;
        cmp_t  pos;
        cmp_t  count;
        word_t word;
    } cell_ctrl_t;

endpackage

// ===== rtl/ivt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivt_cell
// One table entry: holds a word, compares and reads it out on capture, and
// loads from the request, its left neighbor or its right neighbor on apply.
// ----------------------------------------------------------------------------
module ivt_cell (
    input  logic               clk,
    input  ivt_pkg::cell_ctrl_t ctrl,
    input  ivt_pkg::cmp_t      idx,
    input  ivt_pkg::word_t     left_word,
    input  ivt_pkg::word_t     right_word,
    input  logic               after_hit,
    output ivt_pkg::word_t     word,
    output logic               hit,
    output ivt_pkg::word_t     rd_word
);
    import ivt_pkg::*;

    word_t word_reg;
    word_t word_next;
    logic  hit_reg;
    word_t rd_reg;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.apply)
        begin
            case (ctrl.kind)
                REQ_SET:
                begin
                    if (idx == ctrl.pos)
                        word_next = ctrl.word;
                end
                REQ_INSERT:
                begin
                    if (idx == ctrl.pos)
                        word_next = ctrl.word;
                    else if (idx > ctrl.pos)
                        word_next = left_word;
                end
                REQ_ERASE:
                begin
                    if (idx >= ctrl.pos)
                        word_next = right_word;
                end
                REQ_PUSH:
                begin
                    if (idx == ctrl.count)
                        word_next = ctrl.word;
                end
                REQ_REMOVE:
                begin
                    if (after_hit)
                        word_next = right_word;
                end
                default:
                begin
                    word_next = word_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (ctrl.capture)
        begin
            hit_reg <= (word_reg == ctrl.word) && (idx < ctrl.count);
            rd_reg  <= (idx == ctrl.pos) ? word_reg : '0;
        end
    end

    assign word    = word_reg;
    assign hit     = hit_reg;
    assign rd_word = rd_reg;

endmodule

// ===== rtl/indexed_vector_table.sv =====
`timescale 1ns / 1ps
// Each accepted request is handled in steps: on acceptance all cells compare and
// read out in parallel, then S_APPLY shifts or loads the cell chain and the
// length and registers the result onto m_tvalid; s_tready is low in S_APPLY.
// A result waiting on m_tready stalls the apply step of the next request.
// Reset clears the length and the handshake state; entry contents are kept.
// ----------------------------------------------------------------------------
// indexed_vector_table
// Ordered word table with get, set, insert, erase, push, pop, remove-by-value
// and clear, built as a chain of shifting cells.
// ----------------------------------------------------------------------------
module indexed_vector_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] position, [38:7] word_in, [39] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] word_out, [38:32] count_now, [39] zero
    output logic [2:0]  m_tuser    // [2:0] status
);
    import ivt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    state_t           state_reg;
    req_t             kind_reg;
    logic [POS_W-1:0] pos_reg;
    word_t            req_word_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    logic [DATA_W-1:0] word_out_reg;

    cell_ctrl_t       ctrl;
    word_t            cell_word [DEPTH];
    word_t            cell_rd   [DEPTH];
    logic [DEPTH-1:0] hits;
    logic [DEPTH-1:0] below_hit;
    logic             found;
    word_t            rd_any;
    logic             in_fire;
    logic             done;
    cmp_t             pos_ext;
    cmp_t             cnt_ext;
    logic             full;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign done     = (state_reg == S_APPLY) && (!out_valid_reg || m_tready);
    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(DEPTH));

    assign below_hit = (hits - {{(DEPTH-1){1'b0}}, 1'b1}) & ~hits;
    assign found     = |hits;

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        case (kind_reg)
            REQ_GET, REQ_SET:
            begin
                if (pos_ext >= cnt_ext)
                    status_next = ST_RANGE;
            end
            REQ_INSERT:
            begin
                if (pos_ext > cnt_ext)
                    status_next = ST_RANGE;
                else if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            REQ_ERASE:
            begin
                if (pos_ext >= cnt_ext)
                    status_next = ST_RANGE;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            REQ_PUSH:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            REQ_POP:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            REQ_REMOVE:
            begin
                if (!found)
                    status_next = ST_MISSING;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    always_comb
    begin
        ctrl.capture = in_fire;
        ctrl.apply   = done && (status_next == ST_OK);
        ctrl.count   = cnt_ext;
        if (state_reg == S_IDLE)
        begin
            ctrl.kind = req_t'(s_tuser[KIND_W-1:0]);
            ctrl.pos  = CMP_W'(s_tdata[POS_W-1:0]);
            ctrl.word = s_tdata[POS_W +: WORD_BITS];
        end
        else
        begin
            ctrl.kind = kind_reg;
            ctrl.pos  = pos_ext;
            ctrl.word = req_word_reg;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t left_w;
        word_t right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = cell_word[i+1];
        end

        ivt_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .idx        (CMP_W'(i)),
            .left_word  (left_w),
            .right_word (right_w),
            .after_hit  (~below_hit[i]),
            .word       (cell_word[i]),
            .hit        (hits[i]),
            .rd_word    (cell_rd[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            word_out_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                        state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (done)
                    begin
                        state_reg     <= S_IDLE;
                        count_reg     <= count_next;
                        out_valid_reg <= 1'b1;
                        status_reg    <= status_next;
                        word_out_reg  <= ((kind_reg == REQ_GET) && (status_next == ST_OK))
                                         ? DATA_W'(rd_any) : '0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg     <= req_t'(s_tuser[KIND_W-1:0]);
            pos_reg      <= s_tdata[POS_W-1:0];
            req_word_reg <= s_tdata[POS_W +: WORD_BITS];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, POS_W'(count_reg), word_out_reg};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("table length beyond capacity");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result raised without a request in flight");

    a_hold_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(count_reg))
        else $error("length changed while a result waits");

    a_error_keeps_length: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status_next != ST_OK) |=> $stable(count_reg))
        else $error("failed request changed the length");
`endif

endmodule

// ===== tb/ivt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivt_checker
// Watches both stream channels of the indexed vector table. Keeps its own copy
// of the table contents and length, predicts the response of every accepted
// request, and compares each accepted response field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module ivt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,    // [6:0] position, [38:7] word_in, [39] zero
    input  logic [2:0]  s_tuser,    // [2:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // [31:0] word_out, [38:32] count_now, [39] zero
    input  logic [2:0]  m_tuser,    // [2:0] status
    output int          mismatches,
    output int          pending,
    output int          table_len
);
    import ivt_pkg::*;

    typedef struct packed {
        status_t    status;
        word_t      word_out;
        logic [6:0] count_now;
    } response_t;

    word_t     shadow_words [DEPTH];
    int        shadow_len = 0;
    response_t response_q [$];
    int        error_cnt = 0;

    task automatic report(input string what, input longint unsigned want,
                          input longint unsigned got);
        $display("[%0t] mismatch: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        error_cnt++;
    endtask

    function automatic response_t table_request(input req_t kind, input int pos,
                                                input word_t word);
        response_t rsp;
        int        hit;
        rsp.status   = ST_OK;
        rsp.word_out = '0;
        case (kind)
            REQ_GET:
                if (pos >= shadow_len) rsp.status = ST_RANGE;
                else rsp.word_out = shadow_words[pos];
            REQ_SET:
                if (pos >= shadow_len) rsp.status = ST_RANGE;
                else shadow_words[pos] = word;
            REQ_INSERT:
                if (pos > shadow_len) rsp.status = ST_RANGE;
                else if (shadow_len >= DEPTH) rsp.status = ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = word;
                    shadow_len++;
                end
            REQ_ERASE:
                if (pos >= shadow_len) rsp.status = ST_RANGE;
                else
                begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            REQ_PUSH:
                if (shadow_len >= DEPTH) rsp.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = word;
                    shadow_len++;
                end
            REQ_POP:
                if (shadow_len == 0) rsp.status = ST_EMPTY;
                else shadow_len--;
            REQ_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < shadow_len; i++)
                    if (hit < 0 && shadow_words[i] == word) hit = i;
                if (hit < 0) rsp.status = ST_MISSING;
                else
                begin
                    for (int i = hit; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            default:
                shadow_len = 0;
        endcase
        rsp.count_now = shadow_len[6:0];
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            response_q.delete();
            shadow_len = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (response_q.size() == 0)
                    report("response with no request outstanding", 0, m_tdata);
                else
                begin
                    want = response_q.pop_front();
                    if (m_tuser !== want.status)
                        report("status", want.status, m_tuser);
                    if (m_tdata[31:0] !== want.word_out)
                        report("word_out", want.word_out, m_tdata[31:0]);
                    if (m_tdata[38:32] !== want.count_now)
                        report("count_now", want.count_now, m_tdata[38:32]);
                end
            end
            if (s_tvalid && s_tready)
                response_q.push_back(table_request(req_t'(s_tuser),
                                                   int'(s_tdata[6:0]), s_tdata[38:7]));
        end
        mismatches <= error_cnt;
        pending    <= response_q.size();
        table_len  <= shadow_len;
    end

endmodule

// ===== tb/tb_indexed_vector_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_vector_table
// Drives table requests into the indexed vector table: a directed pass over
// every request kind and the range, empty and missing statuses, then random
// bursts that grow, shrink or mix the table, under several idle and backpressure
// patterns. A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_indexed_vector_table;
    import ivt_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 430;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } mix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;      // [6:0] position, [38:7] word_in, [39] zero
    logic [2:0]  s_tuser = '0;      // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [31:0] word_out, [38:32] count_now, [39] zero
    logic [2:0]  m_tuser;           // [2:0] status

    int    mismatches;
    int    pending;
    int    table_len;
    int    idle_pct = 0;
    int    stall_pct = 0;
    int    hold_ticket = 0;
    int    hold_served = 0;
    int    hold_left = 0;
    int    quiet = 0;
    word_t value_pool [8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    indexed_vector_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ivt_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending),
        .table_len  (table_len)
    );

    // hold off for a long stretch on request, otherwise stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_ticket)
        begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("indexed_vector_table regression: fail");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic send(input req_t kind, input int pos, input word_t word);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, word, pos[6:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // pause until every outstanding response has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic req_t pick_kind(input mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                if (r < 40) return REQ_PUSH;
                else if (r < 75) return REQ_INSERT;
                else if (r < 83) return REQ_GET;
                else if (r < 90) return REQ_SET;
                else if (r < 94) return REQ_ERASE;
                else if (r < 97) return REQ_POP;
                else return REQ_REMOVE;
            MIX_SHRINK:
                if (r < 25) return REQ_ERASE;
                else if (r < 50) return REQ_POP;
                else if (r < 75) return REQ_REMOVE;
                else if (r < 85) return REQ_GET;
                else if (r < 92) return REQ_SET;
                else if (r < 95) return REQ_PUSH;
                else if (r < 97) return REQ_INSERT;
                else return REQ_CLEAR;
            default:
                if (r < 2) return REQ_CLEAR;
                else return req_t'($urandom_range(0, 6));
        endcase
    endfunction

    function automatic int pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(0, table_len);
        else if (r < 90) return $urandom_range(0, DEPTH);
        else if (r < 95) return table_len;
        else return DEPTH;
    endfunction

    function automatic word_t pick_word();
        if ($urandom_range(0, 99) < 45) return value_pool[$urandom_range(0, 7)];
        else return $urandom;
    endfunction

    task automatic run_burst(input mix_t mix, input int count);
        req_t kind;
        for (int n = 0; n < count; n++)
        begin
            kind = pick_kind(mix);
            if (kind == REQ_REMOVE && $urandom_range(0, 99) < 80)
                send(kind, pick_pos(), value_pool[$urandom_range(0, 7)]);
            else
                send(kind, pick_pos(), pick_word());
        end
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall,
                             input bit with_hold);
        int done;
        int len;
        done = 0;
        idle_pct = sender_idle;
        stall_pct <= receiver_stall;
        while (done < ITEMS_PER_PHASE)
        begin
            len = $urandom_range(40, 140);
            if (with_hold && done == 0)
            begin
                hold_ticket <= hold_ticket + 1;
                run_burst(MIX_GROW, 40);
                len = 40;
            end
            else if (table_len < 24 && $urandom_range(0, 1))
                run_burst(MIX_GROW, len);
            else
                run_burst(mix_t'($urandom_range(0, 2)), len);
            done += len;
        end
        drain();
    endtask

    initial
    begin
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            value_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(REQ_GET,    0, '0);
        send(REQ_POP,    0, '0);
        send(REQ_REMOVE, 0, '0);
        send(REQ_ERASE,  0, '0);
        send(REQ_SET,    0, 32'hFFFF_FFFF);
        send(REQ_INSERT, 1, 32'h1111_1111);
        send(REQ_INSERT, 0, 32'hFFFF_FFFF);
        send(REQ_PUSH,   0, 32'h0000_0000);
        send(REQ_PUSH,   0, 32'hA5A5_A5A5);
        send(REQ_INSERT, 1, 32'h5A5A_5A5A);
        send(REQ_GET,    0, '0);
        send(REQ_GET,    1, '0);
        send(REQ_GET,    3, '0);
        send(REQ_GET,    4, '0);
        send(REQ_SET,    2, 32'h1234_5678);
        send(REQ_GET,    DEPTH, '0);
        send(REQ_ERASE,  1, '0);
        send(REQ_REMOVE, 0, 32'h1234_5678);
        send(REQ_REMOVE, 0, 32'hDEAD_BEEF);
        send(REQ_INSERT, 2, 32'h8000_0001);
        send(REQ_POP,    0, '0);
        send(REQ_CLEAR,  0, '0);
        send(REQ_GET,    0, '0);
        send(REQ_PUSH,   DEPTH, value_pool[1]);
        drain();

        run_phase(0, 0, 1'b1);
        run_phase(80, 0, 1'b0);
        run_phase(0, 80, 1'b0);
        run_phase(31, 31, 1'b0);

        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("indexed_vector_table regression: pass");
        else
            $display("indexed_vector_table regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ivt_pkg.sv
rtl/ivt_cell.sv
rtl/indexed_vector_table.sv
tb/ivt_checker.sv
tb/tb_indexed_vector_table.sv
